>>> hw/rtl/u8d_pkg.sv
// shared types and constants for the utf-8 sequence decoder
package u8d_pkg;

    localparam int unsigned NUM_CONT     = 5;
    localparam int unsigned PAY_W        = 6;
    localparam int unsigned CODE_W       = 31;
    localparam int unsigned LEN_W        = 3;
    localparam int unsigned IN_TDATA_W   = 48;
    localparam int unsigned OUT_TDATA_W  = 40;

    localparam logic [7:0] CONT_MASK     = 8'hC0;
    localparam logic [7:0] CONT_PATTERN  = 8'h80;

    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;
    localparam logic [LEN_W-1:0] LEN_FIVE  = 3'd5;
    localparam logic [LEN_W-1:0] LEN_SIX   = 3'd6;

    // lead classification passed from the first to the second stage
    typedef struct packed {
        logic [LEN_W-1:0]                 len;
        logic [6:0]                       lead_pay;
        logic [NUM_CONT-1:0][PAY_W-1:0]   pay;
        logic                             ok;
    } u8d_cls_t;

endpackage

>>> hw/rtl/u8d_classify.sv
// lead byte classification and continuation check
module u8d_classify (
    input  logic [7:0]                          lead_byte,
    input  logic [u8d_pkg::NUM_CONT-1:0][7:0]   next_bytes,
    output u8d_pkg::u8d_cls_t                   cls
);
    import u8d_pkg::*;

    logic [NUM_CONT-1:0] cont_ok;

    always_comb begin
        cls = '0;
        for (int i = 0; i < NUM_CONT; i++) begin
            cont_ok[i]  = (next_bytes[i] & CONT_MASK) == CONT_PATTERN;
            cls.pay[i]  = next_bytes[i][PAY_W-1:0];
        end
        case (lead_byte) inside
            [8'h00:8'h7F]: begin
                cls.len      = LEN_ONE;
                cls.lead_pay = lead_byte[6:0];
            end
            [8'hC0:8'hDF]: begin
                cls.len      = LEN_TWO;
                cls.lead_pay = {2'b0, lead_byte[4:0]};
            end
            [8'hE0:8'hEF]: begin
                cls.len      = LEN_THREE;
                cls.lead_pay = {3'b0, lead_byte[3:0]};
            end
            [8'hF0:8'hF7]: begin
                cls.len      = LEN_FOUR;
                cls.lead_pay = {4'b0, lead_byte[2:0]};
            end
            [8'hF8:8'hFB]: begin
                cls.len      = LEN_FIVE;
                cls.lead_pay = {5'b0, lead_byte[1:0]};
            end
            [8'hFC:8'hFF]: begin
                cls.len      = LEN_SIX;
                cls.lead_pay = {6'b0, lead_byte[0]};
            end
            default: begin
                // lone continuation byte
                cls.len      = LEN_ONE;
                cls.lead_pay = '0;
            end
        endcase
        // every continuation the length needs must match 10xxxxxx
        cls.ok = 1'b1;
        for (int i = 0; i < NUM_CONT; i++) begin
            if ((LEN_W'(i + 1) < cls.len) && !cont_ok[i]) begin
                cls.ok = 1'b0;
            end
        end
    end

endmodule

>>> hw/rtl/u8d_assemble.sv
// code point assembly from lead and continuation payloads
module u8d_assemble (
    input  u8d_pkg::u8d_cls_t               cls,
    output logic [u8d_pkg::CODE_W-1:0]      code
);
    import u8d_pkg::*;

    always_comb begin
        case (cls.len)
            LEN_ONE:   code = {24'b0, cls.lead_pay};
            LEN_TWO:   code = {20'b0, cls.lead_pay[4:0], cls.pay[0]};
            LEN_THREE: code = {15'b0, cls.lead_pay[3:0], cls.pay[0], cls.pay[1]};
            LEN_FOUR:  code = {10'b0, cls.lead_pay[2:0], cls.pay[0], cls.pay[1],
                               cls.pay[2]};
            LEN_FIVE:  code = {5'b0, cls.lead_pay[1:0], cls.pay[0], cls.pay[1],
                               cls.pay[2], cls.pay[3]};
            LEN_SIX:   code = {cls.lead_pay[0], cls.pay[0], cls.pay[1], cls.pay[2],
                               cls.pay[3], cls.pay[4]};
            default:   code = '0;
        endcase
    end

endmodule

>>> hw/rtl/utf8_sequence_decoder.sv
// top level of the legacy utf-8 sequence decoder (1 to 6 byte forms)
// decodes one character from a six-byte window that starts at a lead byte and
// returns the code point and how many bytes to advance. leads 0xfc..0xff count
// as six-byte leads, a lone continuation byte gives code 0 and advance 1, and
// any needed continuation byte that is not 10xxxxxx gives code 0 and advance 1.
// overlong forms pass through. one transaction is accepted every cycle while
// s_tready is high; there are three register stages (classify register,
// assembly register, output register), and a transaction passes through them
// in that order before m_tvalid rises with its result. each stage holds its
// own valid bit and the ready chain lets stages fill bubbles, so a stalled
// output keeps taking input until all three stages are full
module utf8_sequence_decoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // lead_byte[7:0], next_byte_1[15:8], next_byte_2[23:16],
    // next_byte_3[31:24], next_byte_4[39:32], next_byte_5[47:40]
    input  logic [u8d_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // code_point[30:0], bytes_consumed[33:31], zero pad[39:34]
    output logic [u8d_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import u8d_pkg::*;

    // stage handshake
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_ready, s2_ready, s3_ready;

    // stage payloads
    u8d_cls_t            cls_next;
    u8d_cls_t            s1_cls_reg;
    logic [CODE_W-1:0]   code_next;
    logic [CODE_W-1:0]   s2_code_reg;
    logic [LEN_W-1:0]    s2_len_reg;
    logic                s2_ok_reg;
    logic [CODE_W-1:0]   s3_code_reg;
    logic [LEN_W-1:0]    s3_len_reg;

    logic [NUM_CONT-1:0][7:0] next_bytes;

    // a stage takes new data when it is empty or its contents move on
    assign s3_ready = !s3_valid_reg || m_tready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_tready = s1_ready;

    assign next_bytes = s_tdata[IN_TDATA_W-1:8];

    // stage 1: classify the lead and check continuations
    u8d_classify u_classify (
        .lead_byte  (s_tdata[7:0]),
        .next_bytes (next_bytes),
        .cls        (cls_next)
    );

    // stage 2: splice payload bits into the code point
    u8d_assemble u_assemble (
        .cls  (s1_cls_reg),
        .code (code_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            s1_cls_reg <= cls_next;
        end
        if (s2_ready) begin
            s2_code_reg <= code_next;
            s2_len_reg  <= s1_cls_reg.len;
            s2_ok_reg   <= s1_cls_reg.ok;
        end
        // stage 3: a bad sequence collapses to code 0, advance 1
        if (s3_ready) begin
            s3_code_reg <= s2_ok_reg ? s2_code_reg : '0;
            s3_len_reg  <= s2_ok_reg ? s2_len_reg : LEN_ONE;
        end
    end

    assign m_tvalid = s3_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - CODE_W - LEN_W){1'b0}}, s3_len_reg, s3_code_reg};

endmodule
